// ===== rtl/core/mcpm_pkg.sv =====
// Shared constants, codes and controller/datapath handshake structs for the PCM mixer.
// No dependencies; every other file in rtl/core refers to this package.
package mcpm_pkg;

  localparam int CLIENT_SLOTS  = 4;
  localparam int FIFO_SAMPLES  = 2048;
  localparam int PERIOD_FRAMES = 64;

  localparam int SAMPLE_W    = 16;
  localparam int CNT_W       = 32;
  localparam int RING_FILL_W = 12;
  localparam int CODE_W      = 2;

  localparam int SLOT_W    = (CLIENT_SLOTS > 1) ? $clog2(CLIENT_SLOTS) : 1;
  localparam int PTR_W     = $clog2(FIFO_SAMPLES);
  localparam int FILL_W    = $clog2(FIFO_SAMPLES + 1);
  localparam int ADDR_W    = $clog2(CLIENT_SLOTS * FIFO_SAMPLES);
  localparam int ACC_DEPTH = 2 * PERIOD_FRAMES;
  localparam int ACC_W     = $clog2(ACC_DEPTH);
  localparam int NEED_W    = $clog2(ACC_DEPTH + 1);
  localparam int FR_W      = (PERIOD_FRAMES > 1) ? $clog2(PERIOD_FRAMES) : 1;

  localparam logic [CODE_W-1:0] CH_MONO = 2'd1;
  localparam logic [CODE_W-1:0] CH_RESET = 2'd2;
  localparam logic KIND_STATUS = 1'b0;
  localparam logic KIND_FRAME  = 1'b1;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_OPEN  = 2'd1,
    OP_CLOSE = 2'd2,
    OP_FLUSH = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NOT_OPEN = 2'd1,
    ST_NO_FREE  = 2'd2
  } status_e;

  typedef struct packed {
    logic latch;
    logic exec_ctrl;
    logic push_l;
    logic push_r;
    logic mix_start;
    logic mix_sel;
    logic mix_step;
    logic mix_done;
    logic rd_l;
    logic rd_r;
    logic load_status;
    logic load_frame;
  } cmd_t;

  typedef struct packed {
    op_e  op;
    logic valid;
    logic stereo;
    logic out_free;
    logic period_ready;
    logic sel_run;
    logic last_slot;
    logic run_last;
    logic frame_last;
  } stat_t;

endpackage

// ===== rtl/core/mcpm_in_if.sv =====
// Input item channel: valid/ready handshake with op, client and one frame of samples.
// Depends on mcpm_pkg for field widths.
interface mcpm_in_if;
  logic                                valid;
  logic                                ready;
  logic [mcpm_pkg::CODE_W-1:0]         op;
  logic [mcpm_pkg::CODE_W-1:0]         client;
  logic signed [mcpm_pkg::SAMPLE_W-1:0] left;
  logic signed [mcpm_pkg::SAMPLE_W-1:0] right;

  modport source (output valid, op, client, left, right, input ready);
  modport sink   (input valid, op, client, left, right, output ready);
endinterface

// ===== rtl/core/mcpm_out_if.sv =====
// Result channel: valid/ready handshake carrying status results and mixed frames.
// Depends on mcpm_pkg for field widths.
interface mcpm_out_if;
  logic                                   valid;
  logic                                   ready;
  logic                                   kind;
  logic [mcpm_pkg::CODE_W-1:0]            status;
  logic [mcpm_pkg::CODE_W-1:0]            slot;
  logic signed [mcpm_pkg::SAMPLE_W-1:0]   mix_left;
  logic signed [mcpm_pkg::SAMPLE_W-1:0]   mix_right;
  logic                                   last;
  logic [mcpm_pkg::RING_FILL_W-1:0]       ring_fill;
  logic [mcpm_pkg::CNT_W-1:0]             overflow_count;
  logic [mcpm_pkg::CNT_W-1:0]             underrun_count;

  modport source (output valid, kind, status, slot, mix_left, mix_right, last, ring_fill,
                  overflow_count, underrun_count, input ready);
  modport sink   (input valid, kind, status, slot, mix_left, mix_right, last, ring_fill,
                  overflow_count, underrun_count, output ready);
endinterface

// ===== rtl/core/mcpm_ctrl.sv =====
// Sequencer for the mixer: steps each item through execute, push, mix and frame readout.
// Depends on mcpm_pkg; drives mcpm_dp through cmd_t and watches stat_t.
module mcpm_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  mcpm_pkg::stat_t stat_i,
  output mcpm_pkg::cmd_t  cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_EXEC,
    S_PUSH_R,
    S_CHECK,
    S_EMIT_STAT,
    S_MIX_SEL,
    S_MIX_RUN,
    S_MIX_DRAIN,
    S_RD_L,
    S_RD_R,
    S_EMIT_FRAME
  } state_e;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    cmd_o      = '0;
    state_d    = state_q;
    in_ready_o = (state_q == S_IDLE);
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.latch = 1'b1;
          state_d     = S_EXEC;
        end
      end
      S_EXEC: begin
        if (stat_i.op == mcpm_pkg::OP_WRITE && stat_i.valid) begin
          cmd_o.push_l = 1'b1;
          state_d      = stat_i.stereo ? S_PUSH_R : S_CHECK;
        end else if (stat_i.out_free) begin
          cmd_o.exec_ctrl = 1'b1;
          state_d         = S_IDLE;
        end
      end
      S_PUSH_R: begin
        cmd_o.push_r = 1'b1;
        state_d      = S_CHECK;
      end
      S_CHECK: begin
        if (stat_i.period_ready) begin
          cmd_o.mix_start = 1'b1;
          state_d         = S_MIX_SEL;
        end else begin
          state_d = S_EMIT_STAT;
        end
      end
      S_EMIT_STAT: begin
        if (stat_i.out_free) begin
          cmd_o.load_status = 1'b1;
          state_d           = S_IDLE;
        end
      end
      S_MIX_SEL: begin
        cmd_o.mix_sel = 1'b1;
        if (stat_i.sel_run) begin
          state_d = S_MIX_RUN;
        end else if (stat_i.last_slot) begin
          state_d = S_RD_L;
        end
      end
      S_MIX_RUN: begin
        cmd_o.mix_step = 1'b1;
        if (stat_i.run_last) begin
          state_d = S_MIX_DRAIN;
        end
      end
      S_MIX_DRAIN: begin
        cmd_o.mix_done = 1'b1;
        state_d        = stat_i.last_slot ? S_RD_L : S_MIX_SEL;
      end
      S_RD_L: begin
        cmd_o.rd_l = 1'b1;
        state_d    = S_RD_R;
      end
      S_RD_R: begin
        cmd_o.rd_r = 1'b1;
        state_d    = S_EMIT_FRAME;
      end
      S_EMIT_FRAME: begin
        if (stat_i.out_free) begin
          cmd_o.load_frame = 1'b1;
          state_d          = stat_i.frame_last ? S_IDLE : S_RD_L;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/core/mcpm_dp.sv =====
// Mixer datapath: client FIFO memory, slot pointers and counters, mix accumulator, output register.
// Depends on mcpm_pkg; commanded by mcpm_ctrl.
module mcpm_dp (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [mcpm_pkg::CODE_W-1:0]          cfg_data_i,
  input  logic [mcpm_pkg::CODE_W-1:0]          op_i,
  input  logic [mcpm_pkg::CODE_W-1:0]          client_i,
  input  logic signed [mcpm_pkg::SAMPLE_W-1:0] left_i,
  input  logic signed [mcpm_pkg::SAMPLE_W-1:0] right_i,
  input  mcpm_pkg::cmd_t                       cmd_i,
  output mcpm_pkg::stat_t                      stat_o,
  input  logic                                 out_ready_i,
  output logic                                 out_valid_o,
  output logic                                 kind_o,
  output logic [mcpm_pkg::CODE_W-1:0]          status_o,
  output logic [mcpm_pkg::CODE_W-1:0]          slot_o,
  output logic signed [mcpm_pkg::SAMPLE_W-1:0] mix_left_o,
  output logic signed [mcpm_pkg::SAMPLE_W-1:0] mix_right_o,
  output logic                                 last_o,
  output logic [mcpm_pkg::RING_FILL_W-1:0]     ring_fill_o,
  output logic [mcpm_pkg::CNT_W-1:0]           overflow_count_o,
  output logic [mcpm_pkg::CNT_W-1:0]           underrun_count_o
);

  localparam int SLOTS = mcpm_pkg::CLIENT_SLOTS;
  localparam int FIFO  = mcpm_pkg::FIFO_SAMPLES;
  localparam int PER   = mcpm_pkg::PERIOD_FRAMES;

  logic [mcpm_pkg::CODE_W-1:0]   channels_q;
  mcpm_pkg::op_e                 op_q;
  logic [mcpm_pkg::CODE_W-1:0]   client_q;
  logic [mcpm_pkg::SAMPLE_W-1:0] left_q, right_q;

  logic [mcpm_pkg::PTR_W-1:0]  rp_q [SLOTS];
  logic [mcpm_pkg::PTR_W-1:0]  wp_q [SLOTS];
  logic [mcpm_pkg::FILL_W-1:0] fill_q [SLOTS];
  logic                        open_q [SLOTS];
  logic [mcpm_pkg::CNT_W-1:0]  ovf_q [SLOTS];
  logic [mcpm_pkg::CNT_W-1:0]  und_q;

  logic [mcpm_pkg::SLOT_W-1:0] s_q;
  logic                        first_q;
  logic [mcpm_pkg::ACC_W-1:0]  idx_q;
  logic [mcpm_pkg::NEED_W-1:0] got_q;
  logic [mcpm_pkg::FR_W-1:0]   fr_q;
  logic                        pv_q, ppop_q;
  logic [mcpm_pkg::ACC_W-1:0]  pidx_q;
  logic [mcpm_pkg::SAMPLE_W-1:0] hold_l_q;

  logic [mcpm_pkg::SAMPLE_W-1:0] fifo_mem [SLOTS*FIFO];
  logic [mcpm_pkg::SAMPLE_W-1:0] fifo_rd_q;
  logic [mcpm_pkg::SAMPLE_W-1:0] acc_mem [mcpm_pkg::ACC_DEPTH];
  logic [mcpm_pkg::SAMPLE_W-1:0] acc_rd_q;

  logic                          out_valid_q, kind_q, last_q;
  logic [mcpm_pkg::CODE_W-1:0]   status_q, slot_q;
  logic [mcpm_pkg::SAMPLE_W-1:0] mix_l_q, mix_r_q;
  logic [mcpm_pkg::RING_FILL_W-1:0] ring_fill_q;
  logic [mcpm_pkg::CNT_W-1:0]    ovf_out_q, und_out_q;

  logic                          stereo, in_range, valid, free_found, period_ready;
  logic [mcpm_pkg::SLOT_W-1:0]   cs, free_idx;
  logic [mcpm_pkg::NEED_W-1:0]   need, got;
  logic [mcpm_pkg::FILL_W-1:0]   cur_fill, ch_n, drop;
  logic [mcpm_pkg::FILL_W:0]     sum_f;
  logic                          ovfl, pop_now, out_free;
  logic [mcpm_pkg::CNT_W-1:0]    cur_ovf;
  logic [mcpm_pkg::ADDR_W-1:0]   wr_addr, rd_addr;
  logic [mcpm_pkg::ACC_W-1:0]    acc_raddr;
  logic                          acc_re;
  logic signed [mcpm_pkg::SAMPLE_W-1:0] pv_val, acc_old;
  logic signed [mcpm_pkg::SAMPLE_W:0]   acc_sum;
  logic [mcpm_pkg::SAMPLE_W-1:0] acc_wdata;

  function automatic logic [mcpm_pkg::PTR_W-1:0] ptr_add(
    input logic [mcpm_pkg::PTR_W-1:0]  p,
    input logic [mcpm_pkg::FILL_W-1:0] n
  );
    logic [mcpm_pkg::FILL_W:0] sum;
    sum = (mcpm_pkg::FILL_W+1)'(p) + (mcpm_pkg::FILL_W+1)'(n);
    if (sum >= (mcpm_pkg::FILL_W+1)'(FIFO)) begin
      sum = sum - (mcpm_pkg::FILL_W+1)'(FIFO);
    end
    return mcpm_pkg::PTR_W'(sum);
  endfunction

  function automatic logic [mcpm_pkg::ADDR_W-1:0] fifo_addr(
    input logic [mcpm_pkg::SLOT_W-1:0] s,
    input logic [mcpm_pkg::PTR_W-1:0]  p
  );
    return mcpm_pkg::ADDR_W'(mcpm_pkg::ADDR_W'(s) * mcpm_pkg::ADDR_W'(FIFO))
           + mcpm_pkg::ADDR_W'(p);
  endfunction

  always_comb begin
    stereo   = (channels_q != mcpm_pkg::CH_MONO);
    need     = stereo ? mcpm_pkg::NEED_W'(2 * PER) : mcpm_pkg::NEED_W'(PER);
    cs       = mcpm_pkg::SLOT_W'(client_q);
    in_range = (int'(client_q) < SLOTS);
    valid    = in_range && open_q[cs];
    cur_fill = in_range ? fill_q[cs] : '0;
    cur_ovf  = in_range ? ovf_q[cs] : '0;

    free_found   = 1'b0;
    free_idx     = '0;
    period_ready = 1'b0;
    for (int k = SLOTS - 1; k >= 0; k--) begin
      if (!open_q[k]) begin
        free_found = 1'b1;
        free_idx   = mcpm_pkg::SLOT_W'(k);
      end
      if (open_q[k] && fill_q[k] >= mcpm_pkg::FILL_W'(need)) begin
        period_ready = 1'b1;
      end
    end

    ch_n  = stereo ? mcpm_pkg::FILL_W'(2) : mcpm_pkg::FILL_W'(1);
    sum_f = (mcpm_pkg::FILL_W+1)'(fill_q[cs]) + (mcpm_pkg::FILL_W+1)'(ch_n);
    ovfl  = sum_f > (mcpm_pkg::FILL_W+1)'(FIFO);
    drop  = ovfl ? mcpm_pkg::FILL_W'(sum_f - (mcpm_pkg::FILL_W+1)'(FIFO)) : '0;
    if (drop > fill_q[cs]) begin
      drop = fill_q[cs];
    end

    got     = (fill_q[s_q] < mcpm_pkg::FILL_W'(need)) ? mcpm_pkg::NEED_W'(fill_q[s_q]) : need;
    pop_now = mcpm_pkg::NEED_W'(idx_q) < got_q;
    out_free = !out_valid_q || out_ready_i;

    wr_addr = fifo_addr(cs, wp_q[cs]);
    rd_addr = fifo_addr(s_q, rp_q[s_q]);

    acc_re = cmd_i.mix_step || cmd_i.rd_l || cmd_i.rd_r;
    if (cmd_i.mix_step) begin
      acc_raddr = idx_q;
    end else if (cmd_i.rd_l) begin
      acc_raddr = stereo ? mcpm_pkg::ACC_W'({fr_q, 1'b0}) : mcpm_pkg::ACC_W'(fr_q);
    end else begin
      acc_raddr = mcpm_pkg::ACC_W'({fr_q, 1'b1});
    end

    pv_val  = ppop_q ? $signed(fifo_rd_q) : '0;
    acc_old = first_q ? '0 : $signed(acc_rd_q);
    acc_sum = $signed({acc_old[mcpm_pkg::SAMPLE_W-1], acc_old})
            + $signed({pv_val[mcpm_pkg::SAMPLE_W-1], pv_val});
    if (acc_sum > $signed((mcpm_pkg::SAMPLE_W+1)'(32767))) begin
      acc_wdata = 16'h7fff;
    end else if (acc_sum < -$signed((mcpm_pkg::SAMPLE_W+1)'(32768))) begin
      acc_wdata = 16'h8000;
    end else begin
      acc_wdata = acc_sum[mcpm_pkg::SAMPLE_W-1:0];
    end
  end

  always_comb begin
    stat_o.op           = op_q;
    stat_o.valid        = valid;
    stat_o.stereo       = stereo;
    stat_o.out_free     = out_free;
    stat_o.period_ready = period_ready;
    stat_o.sel_run      = open_q[s_q] && (fill_q[s_q] != '0);
    stat_o.last_slot    = (s_q == mcpm_pkg::SLOT_W'(SLOTS - 1));
    stat_o.run_last     = (idx_q == mcpm_pkg::ACC_W'(need - 1'b1));
    stat_o.frame_last   = (fr_q == mcpm_pkg::FR_W'(PER - 1));
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.push_l) begin
      fifo_mem[wr_addr] <= left_q;
    end else if (cmd_i.push_r) begin
      fifo_mem[wr_addr] <= right_q;
    end
    if (cmd_i.mix_step) begin
      fifo_rd_q <= fifo_mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (pv_q) begin
      acc_mem[pidx_q] <= acc_wdata;
    end
    if (acc_re) begin
      acc_rd_q <= acc_mem[acc_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      op_q     <= mcpm_pkg::op_e'(op_i);
      client_q <= client_i;
      left_q   <= left_i;
      right_q  <= right_i;
    end
    pidx_q <= idx_q;
    ppop_q <= pop_now;
    if (cmd_i.mix_sel) begin
      got_q <= got;
    end
    if (cmd_i.rd_r) begin
      hold_l_q <= acc_rd_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      channels_q <= mcpm_pkg::CH_RESET;
      for (int k = 0; k < SLOTS; k++) begin
        rp_q[k]   <= '0;
        wp_q[k]   <= '0;
        fill_q[k] <= '0;
        open_q[k] <= 1'b0;
        ovf_q[k]  <= '0;
      end
      und_q   <= '0;
      s_q     <= '0;
      first_q <= 1'b0;
      idx_q   <= '0;
      fr_q    <= '0;
      pv_q    <= 1'b0;
    end else begin
      pv_q <= cmd_i.mix_step;
      if (cfg_we_i) begin
        channels_q <= cfg_data_i;
      end
      if (cmd_i.exec_ctrl && valid) begin
        if (op_q == mcpm_pkg::OP_CLOSE) begin
          open_q[cs] <= 1'b0;
        end
        if (op_q == mcpm_pkg::OP_CLOSE || op_q == mcpm_pkg::OP_FLUSH) begin
          rp_q[cs]   <= '0;
          wp_q[cs]   <= '0;
          fill_q[cs] <= '0;
        end
      end
      if (cmd_i.exec_ctrl && op_q == mcpm_pkg::OP_OPEN && free_found) begin
        rp_q[free_idx]   <= '0;
        wp_q[free_idx]   <= '0;
        fill_q[free_idx] <= '0;
        ovf_q[free_idx]  <= '0;
        open_q[free_idx] <= 1'b1;
      end
      if (cmd_i.push_l) begin
        rp_q[cs]   <= ptr_add(rp_q[cs], drop);
        wp_q[cs]   <= ptr_add(wp_q[cs], mcpm_pkg::FILL_W'(1));
        fill_q[cs] <= fill_q[cs] - drop + mcpm_pkg::FILL_W'(1);
        if (ovfl) begin
          ovf_q[cs] <= ovf_q[cs] + 1'b1;
        end
      end
      if (cmd_i.push_r) begin
        wp_q[cs]   <= ptr_add(wp_q[cs], mcpm_pkg::FILL_W'(1));
        fill_q[cs] <= fill_q[cs] + mcpm_pkg::FILL_W'(1);
      end
      if (cmd_i.mix_start) begin
        s_q     <= '0;
        first_q <= 1'b1;
        fr_q    <= '0;
      end
      if (cmd_i.mix_sel) begin
        idx_q <= '0;
        if (open_q[s_q] && mcpm_pkg::NEED_W'(got) < need) begin
          und_q <= und_q + 1'b1;
        end
        if (!stat_o.sel_run) begin
          s_q <= s_q + 1'b1;
        end
      end
      if (cmd_i.mix_step) begin
        idx_q <= idx_q + 1'b1;
        if (pop_now) begin
          rp_q[s_q]   <= ptr_add(rp_q[s_q], mcpm_pkg::FILL_W'(1));
          fill_q[s_q] <= fill_q[s_q] - mcpm_pkg::FILL_W'(1);
        end
      end
      if (cmd_i.mix_done) begin
        s_q     <= s_q + 1'b1;
        first_q <= 1'b0;
      end
      if (cmd_i.load_frame) begin
        fr_q <= fr_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.exec_ctrl || cmd_i.load_status || cmd_i.load_frame) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec_ctrl) begin
      kind_q    <= mcpm_pkg::KIND_STATUS;
      mix_l_q   <= '0;
      mix_r_q   <= '0;
      last_q    <= 1'b0;
      und_out_q <= und_q;
      if (op_q == mcpm_pkg::OP_OPEN) begin
        status_q    <= free_found ? mcpm_pkg::ST_OK : mcpm_pkg::ST_NO_FREE;
        slot_q      <= free_found ? mcpm_pkg::CODE_W'(free_idx) : '0;
        ring_fill_q <= '0;
        ovf_out_q   <= '0;
      end else if (!valid) begin
        status_q    <= mcpm_pkg::ST_NOT_OPEN;
        slot_q      <= client_q;
        ring_fill_q <= mcpm_pkg::RING_FILL_W'(cur_fill);
        ovf_out_q   <= cur_ovf;
      end else begin
        status_q    <= mcpm_pkg::ST_OK;
        slot_q      <= client_q;
        ring_fill_q <= '0;
        ovf_out_q   <= cur_ovf;
      end
    end else if (cmd_i.load_status || cmd_i.load_frame) begin
      kind_q      <= cmd_i.load_frame ? mcpm_pkg::KIND_FRAME : mcpm_pkg::KIND_STATUS;
      status_q    <= mcpm_pkg::ST_OK;
      slot_q      <= client_q;
      mix_l_q     <= cmd_i.load_frame ? hold_l_q : '0;
      mix_r_q     <= (cmd_i.load_frame && stereo) ? acc_rd_q : '0;
      last_q      <= cmd_i.load_frame && stat_o.frame_last;
      ring_fill_q <= mcpm_pkg::RING_FILL_W'(cur_fill);
      ovf_out_q   <= cur_ovf;
      und_out_q   <= und_q;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign kind_o           = kind_q;
  assign status_o         = status_q;
  assign slot_o           = slot_q;
  assign mix_left_o       = mix_l_q;
  assign mix_right_o      = mix_r_q;
  assign last_o           = last_q;
  assign ring_fill_o      = ring_fill_q;
  assign overflow_count_o = ovf_out_q;
  assign underrun_count_o = und_out_q;

`ifndef SYNTHESIS
  a_one_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_i.load_frame && (cmd_i.load_status || cmd_i.exec_ctrl)))
    else $error("two result loads in one cycle");
  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.mix_step && pop_now) |-> (fill_q[s_q] != '0))
    else $error("pop from empty client fifo");
  a_acc_wr_follows_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pv_q |-> $past(cmd_i.mix_step))
    else $error("accumulator write without issued step");
  a_load_sets_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load_frame |=> out_valid_q)
    else $error("frame load did not raise out valid");
`endif

endmodule

// ===== rtl/core/multi_client_pcm_mixer_top.sv =====
// Top level of the multi-client saturating PCM mixer.
// Depends on mcpm_pkg, mcpm_in_if, mcpm_out_if, mcpm_ctrl and mcpm_dp.
//
//   in_if carries one beat per item (op, client, left, right); out_if carries
//   result beats. cfg_we_i/cfg_data_i write the channels register (1 mono,
//   otherwise stereo); the user must write it only while the block is idle,
//   which the block does not enforce. Open, close, flush and a write to a
//   slot that is not open load their status beat in S_EXEC once the output
//   register is free. Any other write steps through accept, push of one or
//   two samples, period check and status load. A write that completes a
//   period in any open client gives a run of PERIOD_FRAMES frame beats, last
//   set on the final one. The mix visits every slot through the FIFO read
//   port, skipping a closed or empty slot and stepping one holding data
//   through need = channels * PERIOD_FRAMES entries before draining it, then
//   reads each frame from the accumulator. One item is in flight at a time;
//   in_if.ready is high between items, also while a finished beat waits on
//   out_if. Reset empties every FIFO, closes all slots, clears counters and
//   selects stereo. A stalled receiver holds the output register and the
//   sequencer waits on it; nothing is dropped.
module multi_client_pcm_mixer_top (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  mcpm_in_if.sink                     in_if,
  mcpm_out_if.source                  out_if,
  input  logic                        cfg_we_i,
  input  logic [mcpm_pkg::CODE_W-1:0] cfg_data_i
);

  mcpm_pkg::cmd_t  cmd;
  mcpm_pkg::stat_t stat;
  logic            in_ready;

  assign in_if.ready = in_ready;

  mcpm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_if.valid),
    .in_ready_o (in_ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  mcpm_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_data_i       (cfg_data_i),
    .op_i             (in_if.op),
    .client_i         (in_if.client),
    .left_i           (in_if.left),
    .right_i          (in_if.right),
    .cmd_i            (cmd),
    .stat_o           (stat),
    .out_ready_i      (out_if.ready),
    .out_valid_o      (out_if.valid),
    .kind_o           (out_if.kind),
    .status_o         (out_if.status),
    .slot_o           (out_if.slot),
    .mix_left_o       (out_if.mix_left),
    .mix_right_o      (out_if.mix_right),
    .last_o           (out_if.last),
    .ring_fill_o      (out_if.ring_fill),
    .overflow_count_o (out_if.overflow_count),
    .underrun_count_o (out_if.underrun_count)
  );

endmodule

// ===== tb/sv/mcpm_tb_if.sv =====
// Testbench-side view of the mixer channels: re-exports nothing, only defines the
// mix_result_t struct of one out_if result beat. Depends on mcpm_pkg.
package mcpm_tb_pkg;
  import mcpm_pkg::*;

  typedef struct packed {
    logic              kind;
    logic [1:0]        status;
    logic [1:0]        slot;
    logic signed [15:0] mix_left;
    logic signed [15:0] mix_right;
    logic              last;
    logic [11:0]       ring_fill;
    logic [31:0]       overflow_count;
    logic [31:0]       underrun_count;
  } mix_result_t;
endpackage

// ===== tb/sv/multi_client_pcm_mixer_top_test.sv =====
// Self-checking test of multi_client_pcm_mixer_top: directed rows then random
// item streams, each result compared with an in-bench mixer predictor.
// Depends on mcpm_pkg, mcpm_tb_pkg and the RTL interfaces.
module multi_client_pcm_mixer_top_test;
  timeunit 1ns;
  timeprecision 1ps;
  import mcpm_pkg::*;
  import mcpm_tb_pkg::*;

  localparam int STALL_LIMIT = 20000;

  typedef struct {
    op_e         op;
    logic [1:0]  client;
    logic [15:0] left;
    logic [15:0] right;
    bit          typed;
    mix_result_t res;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CODE_W-1:0] cfg_data_i = CH_RESET;

  mcpm_in_if  in_if();
  mcpm_out_if out_if();

  multi_client_pcm_mixer_top uut (
    .clk_i(clk_i), .rst_ni(rst_ni), .in_if(in_if), .out_if(out_if),
    .cfg_we_i(cfg_we_i), .cfg_data_i(cfg_data_i)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  logic [15:0] ring [CLIENT_SLOTS][FIFO_SAMPLES];
  int unsigned rd_ptr [CLIENT_SLOTS];
  int unsigned wr_ptr [CLIENT_SLOTS];
  int unsigned fill [CLIENT_SLOTS];
  bit          is_open [CLIENT_SLOTS];
  logic [31:0] ovf_cnt [CLIENT_SLOTS];
  logic [31:0] urun_cnt;
  logic [1:0]  chan_reg;

  mix_result_t pending_results[$];
  int  errors = 0;
  int  frames_seen = 0;
  int  items_sent = 0;
  int  idle_cycles = 0;
  int  rx_gap = 0;
  bit  calm = 1'b0;
  bit  hold_off = 1'b0;
  bit  timed_out = 1'b0;

  function automatic mix_result_t status_beat(logic [1:0] st, logic [1:0] s,
                                              int unsigned f, logic [31:0] o);
    mix_result_t r;
    r = '0;
    r.kind = KIND_STATUS;
    r.status = st;
    r.slot = s;
    r.ring_fill = f[11:0];
    r.overflow_count = o;
    r.underrun_count = urun_cnt;
    return r;
  endfunction

  function automatic logic [15:0] sat_add(logic [15:0] a, logic [15:0] b);
    int v;
    v = int'($signed(a)) + int'($signed(b));
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v[15:0];
  endfunction

  task automatic mixer_predict(op_e op, logic [1:0] c, logic [15:0] l, logic [15:0] r);
    int unsigned ch, need, got, drop;
    logic [15:0] acc [2*PERIOD_FRAMES];
    logic [15:0] v;
    mix_result_t b;
    bit ready_found;
    ch = (chan_reg == CH_MONO) ? 1 : 2;
    if (op == OP_OPEN) begin
      for (int s = 0; s < CLIENT_SLOTS; s++) begin
        if (!is_open[s]) begin
          rd_ptr[s] = 0; wr_ptr[s] = 0; fill[s] = 0; ovf_cnt[s] = 0; is_open[s] = 1;
          pending_results.push_back(status_beat(ST_OK, s[1:0], 0, 0));
          return;
        end
      end
      pending_results.push_back(status_beat(ST_NO_FREE, 2'd0, 0, 0));
      return;
    end
    if (!is_open[c]) begin
      pending_results.push_back(status_beat(ST_NOT_OPEN, c, fill[c], ovf_cnt[c]));
      return;
    end
    if (op == OP_CLOSE || op == OP_FLUSH) begin
      if (op == OP_CLOSE) is_open[c] = 0;
      rd_ptr[c] = 0; wr_ptr[c] = 0; fill[c] = 0;
      pending_results.push_back(status_beat(ST_OK, c, 0, ovf_cnt[c]));
      return;
    end
    if (fill[c] + ch > FIFO_SAMPLES) begin
      drop = fill[c] + ch - FIFO_SAMPLES;
      if (drop > fill[c]) drop = fill[c];
      rd_ptr[c] = (rd_ptr[c] + drop) % FIFO_SAMPLES;
      fill[c] -= drop;
      ovf_cnt[c]++;
    end
    ring[c][wr_ptr[c]] = l; wr_ptr[c] = (wr_ptr[c] + 1) % FIFO_SAMPLES; fill[c]++;
    if (ch == 2) begin
      ring[c][wr_ptr[c]] = r; wr_ptr[c] = (wr_ptr[c] + 1) % FIFO_SAMPLES; fill[c]++;
    end
    need = ch * PERIOD_FRAMES;
    ready_found = 0;
    for (int s = 0; s < CLIENT_SLOTS; s++)
      if (is_open[s] && fill[s] >= need) ready_found = 1;
    if (!ready_found) begin
      pending_results.push_back(status_beat(ST_OK, c, fill[c], ovf_cnt[c]));
      return;
    end
    for (int i = 0; i < 2*PERIOD_FRAMES; i++) acc[i] = '0;
    for (int s = 0; s < CLIENT_SLOTS; s++) begin
      if (!is_open[s]) continue;
      got = (fill[s] < need) ? fill[s] : need;
      if (got < need) urun_cnt++;
      if (got == 0) continue;
      for (int i = 0; i < need; i++) begin
        v = '0;
        if (i < got) begin
          v = ring[s][rd_ptr[s]];
          rd_ptr[s] = (rd_ptr[s] + 1) % FIFO_SAMPLES;
          fill[s]--;
        end
        acc[i] = sat_add(acc[i], v);
      end
    end
    for (int i = 0; i < PERIOD_FRAMES; i++) begin
      b = status_beat(ST_OK, c, fill[c], ovf_cnt[c]);
      b.kind = KIND_FRAME;
      b.mix_left = acc[i*ch];
      b.mix_right = (ch == 2) ? acc[i*2+1] : 16'sd0;
      b.last = (i == PERIOD_FRAMES-1);
      pending_results.push_back(b);
    end
  endtask

  task automatic report_mismatch(string what, mix_result_t got, mix_result_t want);
    errors++;
    $display("mismatch %s: got %p want %p", what, got, want);
  endtask

  // Receiver: random stall bursts, one long hold-off on request.
  always @(negedge clk_i) begin
    if (!rst_ni || hold_off) begin
      out_if.ready <= 1'b0;
    end else if (rx_gap > 0) begin
      out_if.ready <= 1'b0;
      rx_gap <= rx_gap - 1;
    end else if (!calm && $urandom_range(0, 5) == 0) begin
      out_if.ready <= 1'b0;
      rx_gap <= $urandom_range(0, 3);
    end else begin
      out_if.ready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    mix_result_t got, want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      got = '{out_if.kind, out_if.status, out_if.slot, out_if.mix_left, out_if.mix_right,
              out_if.last, out_if.ring_fill, out_if.overflow_count, out_if.underrun_count};
      if (got.kind == KIND_FRAME) frames_seen++;
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected beat", got, '0);
      end else begin
        want = pending_results.pop_front();
        if (got !== want) report_mismatch("result", got, want);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) || hold_off)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (rst_ni && idle_cycles >= STALL_LIMIT && !timed_out) begin
      timed_out = 1'b1;
      $display("FAILED: results differ");
      $finish;
    end
  end

  task automatic send_item(op_e op, logic [1:0] c, logic [15:0] l, logic [15:0] r);
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.op <= op; in_if.client <= c; in_if.left <= l; in_if.right <= r;
    do @(posedge clk_i); while (!in_if.ready);
    mixer_predict(op, c, l, r);
    items_sent++;
    @(negedge clk_i);
  endtask

  task automatic drain_and_set(logic [1:0] ch);
    in_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
    repeat (40) @(negedge clk_i);
    cfg_we_i <= 1'b1; cfg_data_i <= ch;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    chan_reg = ch;
  endtask

  task automatic random_phase(int n);
    op_e op;
    logic [1:0] c;
    int k;
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(0, 99);
      if (k < 80) op = OP_WRITE;
      else if (k < 88) op = OP_OPEN;
      else if (k < 94) op = OP_CLOSE;
      else op = OP_FLUSH;
      c = 2'($urandom_range(0, 3));
      send_item(op, c, 16'($urandom), 16'($urandom));
    end
  endtask

  row_t rows[$];

  initial begin
    mix_result_t want;
    in_if.valid = 1'b0;
    in_if.op = OP_WRITE; in_if.client = '0; in_if.left = '0; in_if.right = '0;
    urun_cnt = '0;
    chan_reg = CH_RESET;
    for (int s = 0; s < CLIENT_SLOTS; s++) begin
      rd_ptr[s] = 0; wr_ptr[s] = 0; fill[s] = 0; is_open[s] = 0; ovf_cnt[s] = '0;
    end
    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    rows.push_back('{OP_WRITE, 2'd3, 16'h7fff, 16'h8000, 1'b1,
                     '{status: ST_NOT_OPEN, slot: 2'd3, default: '0}});
    rows.push_back('{OP_CLOSE, 2'd0, 16'h0, 16'h0, 1'b1,
                     '{status: ST_NOT_OPEN, slot: 2'd0, default: '0}});
    rows.push_back('{OP_FLUSH, 2'd1, 16'h0, 16'h0, 1'b1,
                     '{status: ST_NOT_OPEN, slot: 2'd1, default: '0}});
    for (int s = 0; s < 4; s++)
      rows.push_back('{OP_OPEN, 2'd0, 16'h0, 16'h0, 1'b1,
                       '{status: ST_OK, slot: 2'(s), default: '0}});
    rows.push_back('{OP_OPEN, 2'd0, 16'hffff, 16'hffff, 1'b1,
                     '{status: ST_NO_FREE, slot: 2'd0, default: '0}});
    rows.push_back('{OP_WRITE, 2'd0, 16'h7fff, 16'h8000, 1'b0, '0});
    rows.push_back('{OP_WRITE, 2'd1, 16'h7fff, 16'h8000, 1'b0, '0});
    rows.push_back('{OP_WRITE, 2'd2, 16'h0001, 16'hffff, 1'b0, '0});
    rows.push_back('{OP_FLUSH, 2'd2, 16'h0, 16'h0, 1'b0, '0});
    rows.push_back('{OP_CLOSE, 2'd3, 16'h0, 16'h0, 1'b0, '0});
    rows.push_back('{OP_OPEN, 2'd0, 16'h0, 16'h0, 1'b0, '0});
    foreach (rows[i]) begin
      send_item(rows[i].op, rows[i].client, rows[i].left, rows[i].right);
      if (rows[i].typed) begin
        want = pending_results[$];
        if (want !== rows[i].res) report_mismatch("directed row", want, rows[i].res);
      end
    end
    // Saturating pile-up: PERIOD_FRAMES extreme writes each to slots 1 and 0, in turn.
    for (int i = 0; i < PERIOD_FRAMES; i++) begin
      send_item(OP_WRITE, 2'd1, 16'h7fff, 16'h8000);
      send_item(OP_WRITE, 2'd0, 16'h7fff, 16'h8000);
    end

    drain_and_set(CH_MONO);
    random_phase(40);
    drain_and_set(2'd0);
    // Hold the receiver while writes keep coming.
    fork
      begin
        hold_off = 1'b1;
        repeat (300) @(negedge clk_i);
        hold_off = 1'b0;
      end
      random_phase(40);
    join
    drain_and_set(2'd3);
    random_phase(40);
    drain_and_set(CH_RESET);
    // Reopen slot 0 and run mono traffic.
    drain_and_set(CH_MONO);
    send_item(OP_CLOSE, 2'd0, 16'h0, 16'h0);
    send_item(OP_OPEN, 2'd0, 16'h0, 16'h0);
    random_phase(60);
    calm = 1'b1;
    drain_and_set(CH_RESET);
    random_phase(40);

    in_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
    repeat (50) @(negedge clk_i);
    $display("covered %0d items, %0d mixed frames, mono and stereo, stall and flood",
             items_sent, frames_seen);
    if (errors == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end
endmodule

// ===== filelist.f =====
rtl/core/mcpm_pkg.sv
rtl/core/mcpm_in_if.sv
rtl/core/mcpm_out_if.sv
rtl/core/mcpm_ctrl.sv
rtl/core/mcpm_dp.sv
rtl/core/multi_client_pcm_mixer_top.sv
tb/sv/mcpm_tb_if.sv
tb/sv/multi_client_pcm_mixer_top_test.sv
